FILE: rtl/alpha_unpremultiply_cutoff_top_defines.svh
// ----------------------------------------------------------------------------
// alpha_unpremultiply_cutoff_top_defines.svh
// Assertion macros shared by the checker of the unpremultiply block.
// ----------------------------------------------------------------------------
`ifndef ALPHA_UNPREMULTIPLY_CUTOFF_TOP_DEFINES_SVH
`define ALPHA_UNPREMULTIPLY_CUTOFF_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ALUP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("alup assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ALUP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("alup assertion failed");

`endif

FILE: rtl/alup_pkg.sv
// ----------------------------------------------------------------------------
// alup_pkg
// Types and constants of the alpha unpremultiply block.
// ----------------------------------------------------------------------------
package alup_pkg;

  localparam int unsigned CHAN_W   = 8;
  localparam int unsigned NUM_LANE = 3;   // red, green, blue
  localparam int unsigned NUM_CELL = 8;   // one cell per quotient bit
  localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

  // Input beat
  typedef struct packed {
    logic [CHAN_W-1:0] in_red;
    logic [CHAN_W-1:0] in_green;
    logic [CHAN_W-1:0] in_blue;
    logic [CHAN_W-1:0] in_alpha;
  } alup_in_t;

  // Output beat
  typedef struct packed {
    logic [CHAN_W-1:0] out_red;
    logic [CHAN_W-1:0] out_green;
    logic [CHAN_W-1:0] out_blue;
    logic [CHAN_W-1:0] out_alpha;
  } alup_out_t;

  // One color channel inside the divider chain
  typedef struct packed {
    logic [CHAN_W-1:0] rem;    // partial remainder
    logic [CHAN_W-1:0] work;   // dividend bits left, quotient bits shifted in
    logic              sat;    // quotient above 255
  } alup_lane_t;

  // Everything one cell hands to the next
  typedef struct packed {
    alup_lane_t [NUM_LANE-1:0] lane;
    logic [CHAN_W-1:0]         alpha;
    logic                      clear;  // alpha below cutoff
  } alup_stage_t;

endpackage

FILE: rtl/alup_prep.sv
// ----------------------------------------------------------------------------
// alup_prep
// Entry stage: forms the rounded dividend c*255 + alpha/2 per channel,
// flags saturation and the below-cutoff case.
// ----------------------------------------------------------------------------
module alup_prep (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [7:0]            cutoff,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  alup_pkg::alup_in_t    in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output alup_pkg::alup_stage_t out_stage
);
  import alup_pkg::*;

  logic        valid_r;
  alup_stage_t stage_r, stage_nxt;
  logic [CHAN_W-1:0] chan [NUM_LANE];
  logic [2*CHAN_W-1:0] dvd [NUM_LANE];

  assign chan[0] = in_data.in_red;
  assign chan[1] = in_data.in_green;
  assign chan[2] = in_data.in_blue;

  // Dividend and saturation per channel; a cutoff of zero acts as one
  always_comb begin
    stage_nxt.alpha = in_data.in_alpha;
    stage_nxt.clear = (in_data.in_alpha < cutoff) || (in_data.in_alpha == '0);
    for (int i = 0; i < NUM_LANE; i++) begin
      dvd[i] = {chan[i], {CHAN_W{1'b0}}} - {{CHAN_W{1'b0}}, chan[i]}
             + {{(CHAN_W+1){1'b0}}, in_data.in_alpha[CHAN_W-1:1]};
      stage_nxt.lane[i].rem  = dvd[i][2*CHAN_W-1:CHAN_W];
      stage_nxt.lane[i].work = dvd[i][CHAN_W-1:0];
      stage_nxt.lane[i].sat  = (dvd[i][2*CHAN_W-1:CHAN_W] >= in_data.in_alpha);
    end
  end

  assign in_ready = !valid_r || out_ready;

  // Stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stage_r <= stage_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_stage = stage_r;

endmodule

FILE: rtl/alup_cell.sv
// ----------------------------------------------------------------------------
// alup_cell
// One restoring-division step for all three channels: shifts in one
// dividend bit, trial-subtracts alpha and produces one quotient bit.
// ----------------------------------------------------------------------------
module alup_cell (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  alup_pkg::alup_stage_t in_stage,
  output logic                  out_valid,
  input  logic                  out_ready,
  output alup_pkg::alup_stage_t out_stage
);
  import alup_pkg::*;

  logic        valid_r;
  alup_stage_t stage_r, stage_nxt;
  logic [CHAN_W:0] trial [NUM_LANE];
  logic [CHAN_W:0] diff  [NUM_LANE];
  logic            ge    [NUM_LANE];

  // Trial subtract per lane
  always_comb begin
    stage_nxt.alpha = in_stage.alpha;
    stage_nxt.clear = in_stage.clear;
    for (int i = 0; i < NUM_LANE; i++) begin
      trial[i] = {in_stage.lane[i].rem, in_stage.lane[i].work[CHAN_W-1]};
      diff[i]  = trial[i] - {1'b0, in_stage.alpha};
      ge[i]    = (trial[i] >= {1'b0, in_stage.alpha});
      stage_nxt.lane[i].rem  = ge[i] ? diff[i][CHAN_W-1:0] : trial[i][CHAN_W-1:0];
      stage_nxt.lane[i].work = {in_stage.lane[i].work[CHAN_W-2:0], ge[i]};
      stage_nxt.lane[i].sat  = in_stage.lane[i].sat;
    end
  end

  assign in_ready = !valid_r || out_ready;

  // Cell valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  // Cell payload
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stage_r <= stage_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_stage = stage_r;

endmodule

FILE: rtl/alpha_unpremultiply_cutoff_top.sv
// ----------------------------------------------------------------------------
// alpha_unpremultiply_cutoff_top
// Premultiplied RGBA to straight RGBA with an alpha cutoff.
// ----------------------------------------------------------------------------
// Takes one pixel per clock and delivers one pixel per clock when the output
// side keeps ready high. There is one entry stage that forms the rounded
// dividend c*255 + alpha/2, then a chain of 8 division cells, each
// producing one quotient bit for red, green and blue at once. Quotients above
// 255 saturate; opaque pixels come out unchanged because dividing by 255 is
// exact. Alpha below the cutoff gives transparent black. Every stage holds
// its beat under back-pressure and bubbles collapse, so the block keeps
// accepting while the chain has room. The cutoff write port is always ready
// and should only be written while no pixel is in flight.
// ----------------------------------------------------------------------------
module alpha_unpremultiply_cutoff_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  alup_pkg::alup_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output alup_pkg::alup_out_t out_data
);
  import alup_pkg::*;

  logic [CHAN_W-1:0] cutoff_r;
  logic        vld [NUM_CELL+1];
  logic        rdy [NUM_CELL+1];
  alup_stage_t stg [NUM_CELL+1];
  alup_stage_t last;
  logic [CHAN_W-1:0] res [NUM_LANE];

  // Cutoff register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cutoff_r <= 8'd1;
    end else if (cfg_valid) begin
      cutoff_r <= cfg_data;
    end
  end

  // Entry stage
  alup_prep u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .cutoff    (cutoff_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (vld[0]),
    .out_ready (rdy[0]),
    .out_stage (stg[0])
  );

  // Division chain
  for (genvar g = 0; g < NUM_CELL; g++) begin : g_cell
    alup_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (vld[g]),
      .in_ready  (rdy[g]),
      .in_stage  (stg[g]),
      .out_valid (vld[g+1]),
      .out_ready (rdy[g+1]),
      .out_stage (stg[g+1])
    );
  end

  assign rdy[NUM_CELL] = out_ready;
  assign out_valid     = vld[NUM_CELL];
  assign last          = stg[NUM_CELL];

  // Final select: clear, saturate or quotient
  always_comb begin
    for (int i = 0; i < NUM_LANE; i++) begin
      if (last.clear) begin
        res[i] = '0;
      end else if (last.lane[i].sat) begin
        res[i] = CHAN_MAX;
      end else begin
        res[i] = last.lane[i].work;
      end
    end
  end

  assign out_data.out_red   = res[0];
  assign out_data.out_green = res[1];
  assign out_data.out_blue  = res[2];
  assign out_data.out_alpha = last.clear ? '0 : last.alpha;

endmodule

FILE: rtl/alup_checker.sv
// ----------------------------------------------------------------------------
// alup_checker
// Port-level checks of the unpremultiply block, bound to its top level.
// ----------------------------------------------------------------------------
`include "alpha_unpremultiply_cutoff_top_defines.svh"

module alup_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                cfg_valid,
  input logic                cfg_ready,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input alup_pkg::alup_out_t out_data
);
  import alup_pkg::*;

  // A stalled output beat holds
  `ALUP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

  // Zero alpha always means transparent black (red, green, blue sit above alpha)
  `ALUP_ASSERT_NOW(a_clear_black, out_valid && (out_data.out_alpha == '0), out_data[4*CHAN_W-1:CHAN_W] == '0)

  // With the output empty the chain has room for a new beat
  `ALUP_ASSERT_NOW(a_room, !out_valid, in_ready)

  // Cutoff writes never stall
  `ALUP_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready)

endmodule

bind alpha_unpremultiply_cutoff_top alup_checker u_alup_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

FILE: sim/alpha_unpremultiply_cutoff_top_test.sv
// ----------------------------------------------------------------------------
// alpha_unpremultiply_cutoff_top_test
// Self-checking bench for the premultiplied-to-straight RGBA converter.
// ----------------------------------------------------------------------------
// Pixels are queued by the stimulus process and driven one beat at a time.
// Each accepted input beat is run through a local model of the conversion
// (opaque pass-through, rounded divide with saturation, clear below the
// cutoff). The expected pixel is then queued, and every output beat is
// compared field by field with the oldest one. The cutoff is rewritten
// between phases only when no beat is in flight. The values used include
// 0, 1 and 255. Both sides stall at random, and the receiver holds off once
// for a long stretch so that the pipe backs up into the input.
// ----------------------------------------------------------------------------
module alpha_unpremultiply_cutoff_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import alup_pkg::*;

  localparam int unsigned IDLE_PCT   = 15;
  localparam int unsigned HOLD_LEN   = 80;
  localparam int unsigned DRAIN_WAIT = 12;   // pipe latency plus margin
  localparam int unsigned STALL_MAX  = 2000;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [7:0] cfg_data = 8'd0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  alup_in_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  alup_out_t out_data;

  alup_in_t  pending_pixels[$];
  alup_out_t expected_pixels[$];
  logic [7:0] alpha_floor = 8'd1;   // mirror of the cutoff register
  int unsigned beats_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches   = 0;

  alpha_unpremultiply_cutoff_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #6 clk = ~clk;

  // Straight-alpha pixel for one premultiplied pixel under a given cutoff
  function automatic alup_out_t straight_pixel(alup_in_t px, logic [7:0] cut);
    alup_out_t   res;
    logic [7:0]  thr;
    logic [7:0]  chan [3];
    int unsigned cv;
    int unsigned av;
    int unsigned q;
    thr = (cut == 8'd0) ? 8'd1 : cut;   // zero behaves as one
    chan[0] = px.in_red;
    chan[1] = px.in_green;
    chan[2] = px.in_blue;
    av = px.in_alpha;
    res = '0;
    if (px.in_alpha == CHAN_MAX) begin
      res.out_alpha = px.in_alpha;
    end else if (px.in_alpha >= thr) begin
      for (int k = 0; k < 3; k++) begin
        cv = chan[k];
        q = (cv * CHAN_MAX + av / 2) / av;
        chan[k] = (q > CHAN_MAX) ? CHAN_MAX : 8'(q);
      end
      res.out_alpha = px.in_alpha;
    end else begin
      chan[0] = 8'd0;
      chan[1] = 8'd0;
      chan[2] = 8'd0;
    end
    res.out_red   = chan[0];
    res.out_green = chan[1];
    res.out_blue  = chan[2];
    return res;
  endfunction

  // Input driver: keeps a beat steady until taken, idles at random
  always @(posedge clk) begin : drive_pixels
    logic took;
    logic calm;
    took = in_valid && in_ready;
    calm = (beats_sent >= 320) && (beats_sent < 420);
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (took) begin
        expected_pixels.push_back(straight_pixel(in_data, alpha_floor));
        beats_sent++;
      end
      if (in_valid && !took) begin
        // hold the offered beat
      end else if (pending_pixels.size() != 0 &&
                   (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
        in_valid <= 1'b1;
        in_data  <= pending_pixels.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output monitor and ready control
  always @(posedge clk) begin : watch_results
    static int unsigned hold_left = 0;
    static logic        held      = 1'b0;
    alup_out_t want;
    logic      calm;
    if (rst_n && out_valid && out_ready) begin
      if (expected_pixels.size() == 0) begin
        $error("out_data: beat %h with no pixel expected", out_data);
        mismatches++;
      end else begin
        want = expected_pixels.pop_front();
        if (out_data.out_red !== want.out_red) begin
          $error("out_red: expected %0d, got %0d", want.out_red, out_data.out_red);
          mismatches++;
        end
        if (out_data.out_green !== want.out_green) begin
          $error("out_green: expected %0d, got %0d", want.out_green, out_data.out_green);
          mismatches++;
        end
        if (out_data.out_blue !== want.out_blue) begin
          $error("out_blue: expected %0d, got %0d", want.out_blue, out_data.out_blue);
          mismatches++;
        end
        if (out_data.out_alpha !== want.out_alpha) begin
          $error("out_alpha: expected %0d, got %0d", want.out_alpha, out_data.out_alpha);
          mismatches++;
        end
      end
      results_seen++;
    end
    calm = (results_seen >= 320) && (results_seen < 420);
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!held && results_seen >= 150 && pending_pixels.size() >= 30) begin
      // one long hold-off so the pipe fills and pushes back on the input
      held = 1'b1;
      hold_left = HOLD_LEN;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Watchdog: too long without any beat on any channel
  always @(posedge clk) begin : watchdog
    static int unsigned quiet = 0;
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet = 0;
    else
      quiet++;
    if (quiet >= STALL_MAX) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic add_pixel(input logic [7:0] r, input logic [7:0] g,
                           input logic [7:0] b, input logic [7:0] a);
    alup_in_t px;
    px.in_red   = r;
    px.in_green = g;
    px.in_blue  = b;
    px.in_alpha = a;
    pending_pixels.push_back(px);
  endtask

  // Single beat on the cutoff port
  task automatic write_cutoff(input logic [7:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    alpha_floor = value;
  endtask

  // Wait until no beat is queued, offered or in flight; checked mid-cycle
  // so the driver's updates of the same edge are already visible
  task automatic drain_pipe();
    while (pending_pixels.size() != 0 || in_valid || expected_pixels.size() != 0)
      @(negedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // Stimulus
  initial begin : stimulus
    logic [7:0]  cuts [6];
    int unsigned counts [6];
    logic [7:0]  a;
    logic [7:0]  cut;
    logic [7:0]  lo;
    logic [7:0]  ch [3];

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset cutoff of one: clear at zero alpha, saturation, rounding, opaque
    add_pixel(8'd0,   8'd0,   8'd0,   8'd0);
    add_pixel(8'd255, 8'd255, 8'd255, 8'd0);
    add_pixel(8'd0,   8'd1,   8'd255, 8'd1);
    add_pixel(8'd1,   8'd0,   8'd0,   8'd1);
    add_pixel(8'd0,   8'd128, 8'd255, 8'd255);
    add_pixel(8'd255, 8'd255, 8'd255, 8'd255);
    add_pixel(8'd1,   8'd2,   8'd3,   8'd2);
    add_pixel(8'd127, 8'd64,  8'd200, 8'd254);
    add_pixel(8'd100, 8'd50,  8'd0,   8'd128);
    add_pixel(8'd170, 8'd85,  8'd255, 8'd170);
    add_pixel(8'd1,   8'd1,   8'd1,   8'd3);
    add_pixel(8'd2,   8'd1,   8'd0,   8'd7);
    drain_pipe();

    // Top cutoff: only opaque pixels survive
    write_cutoff(8'd255);
    add_pixel(8'd254, 8'd100, 8'd0,   8'd254);
    add_pixel(8'd12,  8'd34,  8'd56,  8'd255);
    add_pixel(8'd255, 8'd0,   8'd255, 8'd255);
    add_pixel(8'd1,   8'd1,   8'd1,   8'd1);
    drain_pipe();

    // Cutoff of zero acts as one, no divide by zero
    write_cutoff(8'd0);
    add_pixel(8'd0,   8'd0,   8'd0,   8'd0);
    add_pixel(8'd5,   8'd7,   8'd9,   8'd0);
    add_pixel(8'd1,   8'd0,   8'd1,   8'd1);
    add_pixel(8'd77,  8'd66,  8'd55,  8'd200);
    drain_pipe();

    // Random phases, mostly well-formed premultiplied pixels
    cuts[0] = 8'($urandom_range(2, 254));
    cuts[1] = 8'd255;
    cuts[2] = 8'd1;
    cuts[3] = 8'($urandom_range(2, 254));
    cuts[4] = 8'd0;
    cuts[5] = 8'($urandom_range(128, 254));
    counts[0] = 60;
    counts[1] = 60;
    counts[2] = 200;
    counts[3] = 60;
    counts[4] = 60;
    counts[5] = 60;
    for (int p = 0; p < 6; p++) begin
      cut = cuts[p];
      write_cutoff(cut);
      lo = (cut == 8'd0) ? 8'd1 : cut;
      for (int n = 0; n < counts[p]; n++) begin
        case ($urandom_range(0, 9))
          0, 1, 2: a = 8'($urandom_range(0, 255));
          3:       a = 8'd255;
          4:       a = cut - 8'd1;
          5:       a = cut;
          6:       a = cut + 8'd1;
          7:       a = 8'd0;
          default: a = (lo == 8'd255) ? 8'd255 : 8'($urandom_range(lo, 254));
        endcase
        for (int k = 0; k < 3; k++) begin
          case ($urandom_range(0, 7))
            5:       ch[k] = 8'($urandom_range(0, 255));
            6:       ch[k] = a;
            7:       ch[k] = $urandom_range(0, 1) ? 8'd255 : 8'd0;
            default: ch[k] = 8'($urandom_range(0, a));
          endcase
        end
        add_pixel(ch[0], ch[1], ch[2], a);
      end
      drain_pipe();
    end

    if (mismatches == 0 && expected_pixels.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
